@@ rtl/double_ended_queue_top_assert.svh @@
// Assertion macros used by the checker file dq_checker.sv.
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define DQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/dq_pkg.sv @@
package dq_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_LIST
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_DONE,
		STAT_FULL,
		STAT_EMPTY,
		STAT_LISTED
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LIST_RD,
		S_LIST_DATA
	} state_t;

	// base + off, wrapped into the ring; off is at most DEPTH
	function automatic idx_t wrap_add(idx_t base, cnt_t off);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (s >= (CNT_W+1)'(DEPTH))
			s = s - (CNT_W+1)'(DEPTH);
		return s[IDX_W-1:0];
	endfunction

endpackage

@@ rtl/dq_ram.sv @@
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		// read data holds until the next read
		if (re)
			rdata <= mem[raddr];
	end

endmodule

@@ rtl/double_ended_queue_top.sv @@
// channel | signals                          | direction
// in      | in_valid, in_ready, opcode, value | item in
// out     | out_valid, out_ready, status,     | result out
//         | element, last                    |
// Push, pop and ignored opcodes: one result each.
// List: each stored element is read from the RAM (S_LIST_RD), then loaded
// into the output register (S_LIST_DATA).
// Output stalls hold the result register and block new items.
// arst_n clears pointers, count, FSM and output valid; slot contents are
// not cleared and are only read once written.
module double_ended_queue_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  opcode,
	input  logic signed [31:0]          value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic signed [31:0]          element,
	output logic                        last
);

	dq_pkg::state_t state_q, state_d;
	dq_pkg::idx_t   front_q, front_d;
	dq_pkg::cnt_t   occ_q, occ_d;
	dq_pkg::cnt_t   idx_q;

	logic                      out_valid_q;
	dq_pkg::status_t           status_q;
	logic [dq_pkg::DATA_W-1:0] element_q;
	logic                      last_q;

	logic                      slot_free;
	logic                      accept;
	logic                      go_list;
	logic                      load_item;
	logic                      load_elem;
	logic                      list_last;
	logic                      ram_we;
	logic                      ram_re;
	dq_pkg::idx_t              ram_waddr;
	dq_pkg::idx_t              ram_raddr;
	logic [dq_pkg::DATA_W-1:0] ram_rdata;
	dq_pkg::status_t           res_status;
	logic                      full;
	logic                      empty;
	dq_pkg::idx_t              front_dec;

	assign slot_free = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign full      = (occ_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
	assign empty     = (occ_q == '0);
	assign front_dec = (front_q == '0) ? dq_pkg::IDX_W'(dq_pkg::DEPTH - 1)
	                                   : front_q - 1'b1;
	assign list_last = ((idx_q + 1'b1) == occ_q);
	assign ram_raddr = dq_pkg::wrap_add(front_q, idx_q);

	// item decode: pointer updates, the status of a single result, or the start of a list
	always_comb begin
		front_d    = front_q;
		occ_d      = occ_q;
		ram_we     = 1'b0;
		ram_waddr  = front_q;
		res_status = dq_pkg::STAT_DONE;
		go_list    = 1'b0;
		case (dq_pkg::opcode_t'(opcode))
			dq_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					res_status = dq_pkg::STAT_FULL;
				end else begin
					front_d   = front_dec;
					occ_d     = occ_q + 1'b1;
					ram_waddr = front_dec;
					ram_we    = accept;
				end
			end
			dq_pkg::OP_PUSH_BACK: begin
				if (full) begin
					res_status = dq_pkg::STAT_FULL;
				end else begin
					occ_d     = occ_q + 1'b1;
					ram_waddr = dq_pkg::wrap_add(front_q, occ_q);
					ram_we    = accept;
				end
			end
			dq_pkg::OP_POP_FRONT: begin
				if (empty) begin
					res_status = dq_pkg::STAT_EMPTY;
				end else begin
					front_d = dq_pkg::wrap_add(front_q, dq_pkg::CNT_W'(1));
					occ_d   = occ_q - 1'b1;
				end
			end
			dq_pkg::OP_POP_BACK: begin
				if (empty)
					res_status = dq_pkg::STAT_EMPTY;
				else
					occ_d = occ_q - 1'b1;
			end
			dq_pkg::OP_LIST: begin
				if (empty)
					res_status = dq_pkg::STAT_EMPTY;
				else
					go_list = 1'b1;
			end
			default: begin
				res_status = dq_pkg::STAT_DONE;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dq_pkg::S_IDLE: begin
				if (accept && go_list)
					state_d = dq_pkg::S_LIST_RD;
			end
			dq_pkg::S_LIST_RD: begin
				state_d = dq_pkg::S_LIST_DATA;
			end
			dq_pkg::S_LIST_DATA: begin
				if (slot_free)
					state_d = list_last ? dq_pkg::S_IDLE : dq_pkg::S_LIST_RD;
			end
			default: begin
				state_d = dq_pkg::S_IDLE;
			end
		endcase
	end

	// FSM outputs
	always_comb begin
		in_ready  = 1'b0;
		ram_re    = 1'b0;
		load_elem = 1'b0;
		unique case (state_q)
			dq_pkg::S_IDLE:      in_ready  = slot_free;
			dq_pkg::S_LIST_RD:   ram_re    = 1'b1;
			dq_pkg::S_LIST_DATA: load_elem = slot_free;
			default:             in_ready  = 1'b0;
		endcase
	end

	assign load_item = accept && !go_list;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dq_pkg::S_IDLE;
			front_q     <= '0;
			occ_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				front_q <= front_d;
				occ_q   <= occ_d;
			end
			if (accept)
				idx_q <= '0;
			else if (load_elem)
				idx_q <= idx_q + 1'b1;
			if (load_item || load_elem)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (load_item) begin
			status_q  <= res_status;
			element_q <= '0;
			last_q    <= 1'b1;
		end else if (load_elem) begin
			status_q  <= dq_pkg::STAT_LISTED;
			element_q <= ram_rdata;
			last_q    <= list_last;
		end
	end

	dq_ram #(
		.WIDTH(dq_pkg::DATA_W),
		.DEPTH(dq_pkg::DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign element   = element_q;
	assign last      = last_q;

endmodule

@@ rtl/dq_checker.sv @@
`include "double_ended_queue_top_assert.svh"

module dq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [2:0]         opcode,
	input logic signed [31:0] value,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic signed [31:0] element,
	input logic               last
);

	// a stalled result beat holds
	`DQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(element) && $stable(last), "out beat changed under stall")

	// non-list results are single beats with zero element
	`DQ_ASSERT_NOW(a_plain_last, out_valid && (status != dq_pkg::STAT_LISTED), last && (element == '0), "plain result not last or element nonzero")

	// no item taken while the result slot stays occupied
	`DQ_ASSERT_NOW(a_in_slot, in_valid && in_ready, !out_valid || out_ready, "item accepted while result stalled")

	// mid-list, no new item is taken until the final listed beat is loaded
	`DQ_ASSERT_NEXT(a_list_busy, out_valid && out_ready && (status == dq_pkg::STAT_LISTED) && !last, !in_ready || (out_valid && (status == dq_pkg::STAT_LISTED)), "item accepted during list")

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (.*);

@@ tb/double_ended_queue_checker.sv @@
module double_ended_queue_checker
	import dq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [2:0]               opcode,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [1:0]               status,
	input  logic signed [DATA_W-1:0] element,
	input  logic                     last,
	output int                       errors,
	output int                       pending
);

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] element;
		logic                     last;
	} deque_result_t;

	// shadow of the ring: stored values, front slot and fill level
	logic signed [DATA_W-1:0] ring [DEPTH];
	idx_t                     head;
	cnt_t                     fill;
	deque_result_t            awaited [$];
	deque_result_t            want;
	int                       i;

	function automatic deque_result_t make_result(status_t s, logic signed [DATA_W-1:0] e,
			logic l);
		deque_result_t r;
		r.status = s;
		r.element = e;
		r.last = l;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = '0;
			fill = '0;
			awaited.delete();
			pending = 0;
		end else begin
			// result beat first: it can never belong to an item taken at this edge
			if (out_valid && out_ready) begin
				if (awaited.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing awaited: status %0d element %0d last %0b",
						$time, status, element, last);
				end else begin
					want = awaited.pop_front();
					if (status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
					end
					if (element !== want.element) begin
						errors++;
						$display("%0t: element expected %0d actual %0d",
							$time, want.element, element);
					end
					if (last !== want.last) begin
						errors++;
						$display("%0t: last expected %0b actual %0b",
							$time, want.last, last);
					end
				end
			end

			if (in_valid && in_ready) begin
				case (opcode)
					OP_PUSH_FRONT, OP_PUSH_BACK: begin
						if (fill == cnt_t'(DEPTH)) begin
							awaited.push_back(make_result(STAT_FULL, '0, 1'b1));
						end else begin
							if (opcode == OP_PUSH_FRONT) begin
								head = (head == '0) ? idx_t'(DEPTH - 1) : head - 1'b1;
								ring[head] = value;
							end else begin
								ring[(int'(head) + int'(fill)) % DEPTH] = value;
							end
							fill++;
							awaited.push_back(make_result(STAT_DONE, '0, 1'b1));
						end
					end
					OP_POP_FRONT, OP_POP_BACK: begin
						if (fill == '0) begin
							awaited.push_back(make_result(STAT_EMPTY, '0, 1'b1));
						end else begin
							if (opcode == OP_POP_FRONT)
								head = idx_t'((int'(head) + 1) % DEPTH);
							fill--;
							awaited.push_back(make_result(STAT_DONE, '0, 1'b1));
						end
					end
					OP_LIST: begin
						if (fill == '0) begin
							awaited.push_back(make_result(STAT_EMPTY, '0, 1'b1));
						end else begin
							for (i = 0; i < int'(fill); i++)
								awaited.push_back(make_result(STAT_LISTED,
									ring[(int'(head) + i) % DEPTH], i + 1 == int'(fill)));
						end
					end
					// spare opcodes are ignored but still answer once
					default: awaited.push_back(make_result(STAT_DONE, '0, 1'b1));
				endcase
			end
			pending = awaited.size();
		end
	end

endmodule

@@ tb/double_ended_queue_top_tb.sv @@
module double_ended_queue_top_tb;
	import dq_pkg::*;

	localparam int RANDOM_ITEMS   = 220;
	localparam int STALL_LIMIT    = 2000;
	localparam int SQUEEZE_AT     = 300;
	localparam int SQUEEZE_CYCLES = 250;
	localparam int DRAIN_CYCLES   = 16;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [2:0]               opcode = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] element;
	logic                     last;

	int   errors;
	int   pending;
	logic in_took = 1'b0;
	int   burst_left = 0;
	int   level = 0;
	int   idle_cycles = 0;

	always #1 clk = ~clk;

	double_ended_queue_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.element   (element),
		.last      (last)
	);

	double_ended_queue_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.element   (element),
		.last      (last),
		.errors    (errors),
		.pending   (pending)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_took <= 1'b0;
		else
			in_took <= in_valid && in_ready;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("[double_ended_queue_top] ERROR");
					$finish;
				end
			end
		end
	end

	// offer one item beat, idling between bursts; returns at the negedge after acceptance
	task automatic offer(input logic [2:0] op, input logic signed [DATA_W-1:0] v);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		opcode <= op;
		value <= v;
		in_valid <= 1'b1;
		do @(negedge clk); while (!in_took);
		// rough fill level, only used to steer the random mix
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: if (level < DEPTH) level++;
			OP_POP_FRONT, OP_POP_BACK: if (level > 0) level--;
			default: ;
		endcase
	endtask

	// receiver: random ready patterns, plus one long hold-off to back the block up
	initial begin
		int tick;
		int mode;
		int mode_left;
		tick = 0;
		mode = 0;
		mode_left = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (tick == SQUEEZE_AT) begin
				out_ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(8, 60);
				end
				mode_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					default: out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	initial begin
		logic [2:0]               op;
		logic signed [DATA_W-1:0] v;
		int                       pick;
		int                       n;
		bit                       filling;
		int                       spill;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty store, extremes of value, front wrap, spare opcodes
		offer(OP_LIST, $urandom);
		offer(OP_POP_FRONT, $urandom);
		offer(OP_POP_BACK, $urandom);
		offer(OP_PUSH_BACK, 32'sh7fffffff);
		offer(OP_PUSH_FRONT, 32'sh80000000);
		offer(OP_PUSH_BACK, '0);
		offer(OP_PUSH_FRONT, -32'sd1);
		offer(OP_PUSH_BACK, 32'sh55555555);
		offer(OP_LIST, $urandom);
		offer(OP_POP_FRONT, $urandom);
		offer(OP_POP_BACK, $urandom);
		offer(OP_LIST, $urandom);
		offer(3'(OP_LIST) + 3'd1, $urandom);
		offer(3'(OP_LIST) + 3'd2, $urandom);
		offer(3'(OP_LIST) + 3'd3, $urandom);
		offer(OP_POP_FRONT, $urandom);
		offer(OP_POP_FRONT, $urandom);
		offer(OP_POP_FRONT, $urandom);
		offer(OP_POP_BACK, $urandom);
		offer(OP_LIST, $urandom);
		offer(OP_PUSH_FRONT, $urandom);
		offer(OP_LIST, $urandom);
		offer(OP_POP_BACK, $urandom);

		// alternate fill and drain phases so full and empty are both hit repeatedly
		filling = 1'b1;
		spill = 0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (filling ? (level == DEPTH) : (level == 0)) begin
				spill++;
				if (spill > 3) begin
					filling = !filling;
					spill = 0;
				end
			end
			pick = $urandom_range(0, 99);
			if (pick < 40)
				op = filling ? OP_PUSH_FRONT : OP_POP_FRONT;
			else if (pick < 80)
				op = filling ? OP_PUSH_BACK : OP_POP_BACK;
			else if (pick < 85)
				op = filling ? OP_POP_FRONT : OP_PUSH_FRONT;
			else if (pick < 90)
				op = filling ? OP_POP_BACK : OP_PUSH_BACK;
			else if (pick < 97)
				op = OP_LIST;
			else
				op = 3'(OP_LIST) + 3'($urandom_range(1, 3));
			v = $urandom;
			case ($urandom_range(0, 9))
				0: v = 32'sh7fffffff;
				1: v = 32'sh80000000;
				2: v = '0;
				default: ;
			endcase
			offer(op, v);
		end

		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("[double_ended_queue_top] OK");
		else
			$display("[double_ended_queue_top] ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/double_ended_queue_top.sv
rtl/dq_checker.sv
tb/double_ended_queue_checker.sv
tb/double_ended_queue_top_tb.sv
